// ===== rtl/core/mouse_motion_packet_port_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the mouse motion packet port
// Shared concurrent assertion forms, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef MOUSE_MOTION_PACKET_PORT_ASSERT_SVH
`define MOUSE_MOTION_PACKET_PORT_ASSERT_SVH

// check prop on every clock edge outside reset
`define MMPP_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// check prop on every clock edge, reset included
`define MMPP_ASSERT_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/core/mmpp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpp_pkg
// Types and constants of the mouse motion packet port.
// ----------------------------------------------------------------------------
`default_nettype none

package mmpp_pkg;

   localparam int ACCUM_BITS = 12;

   typedef logic signed [ACCUM_BITS-1:0] accum_type;
   typedef logic signed [5:0]            motion_type;

   typedef enum logic [1:0] {
      REQ_FRAME = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_kind_type;

   localparam accum_type ACCUM_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
   localparam accum_type ACCUM_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};
   localparam accum_type CLAMP_HI  = accum_type'(31);
   localparam accum_type CLAMP_LO  = accum_type'(-31);

   localparam motion_type MOTION_HI = 6'sd31;
   localparam motion_type MOTION_LO = -6'sd31;
   localparam motion_type MOTION_P1 = 6'sd1;
   localparam motion_type MOTION_N1 = -6'sd1;

   localparam logic [2:0] PKT_NONE  = 3'd0;
   localparam logic [2:0] PKT_BYTE1 = 3'd1;
   localparam logic [2:0] PKT_BYTE2 = 3'd2;
   localparam logic [2:0] PKT_BYTE3 = 3'd3;
   localparam logic [2:0] PKT_DONE  = 3'd4;

   localparam logic [7:0] DIR_Y_NEG = 8'h0C;
   localparam logic [7:0] DIR_Y_POS = 8'h08;
   localparam logic [7:0] DIR_X_NEG = 8'h30;
   localparam logic [7:0] DIR_X_POS = 8'h20;

   localparam logic [2:0] STROBE_VALUE = 3'd1;
   localparam logic [3:0] BIT_COUNT    = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/core/mouse_motion_packet_port.sv =====
// ----------------------------------------------------------------------------
// mouse_motion_packet_port
// Controller-port mouse: motion accumulators, packet builder, serial readout.
// ----------------------------------------------------------------------------
// Flow: a word is registered on entry and processed from the entry register,
//   which holds a read until the answer register can take its reply.
// Throughput: one word per cycle; the entry register stalls only when it
//   holds a read while the answer register is full and not taken.
// Reset: synchronous, clears the motion and packet state and the entry and answer valid flags.
`default_nettype none

module mouse_motion_packet_port (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,  // delta_x, delta_y, button_bits, write_value, pad
   input  wire logic [1:0]  req_tuser,  // req_type
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata   // data_bit, pad
);

   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           in_kind_ff;
   logic [7:0]           in_dx_ff, in_dy_ff;
   logic [2:0]           in_btn_ff, in_wval_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_bit_ff, rsp_bit_in;

   logic [7:0]           shift_byte_ff, shift_byte_in;
   logic [3:0]           bit_pointer_ff, bit_pointer_in;
   logic                 strobe_ff, strobe_in;
   mmpp_pkg::accum_type  accum_x_ff, accum_x_in;
   mmpp_pkg::accum_type  accum_y_ff, accum_y_in;
   logic [2:0]           buttons_ff, buttons_in;
   logic [2:0]           pkt_count_ff, pkt_count_in;

   logic                 is_read, proc_word;
   logic                 req_accept;

   logic [mmpp_pkg::ACCUM_BITS:0] sum_x, sum_y;
   mmpp_pkg::motion_type          mot_x, mot_y;
   logic [4:0]                    mag_x, mag_y;
   logic [2:0]                    pkt_next;
   logic                          big_motion;
   logic [7:0]                    btn_bits;
   mmpp_pkg::accum_type           drain_x, drain_y;

   assign is_read    = (in_kind_ff == mmpp_pkg::REQ_READ);
   assign proc_word  = in_valid_ff && (!is_read || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_word;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_bit_ff};

   assign sum_x = {accum_x_ff[mmpp_pkg::ACCUM_BITS-1], accum_x_ff}
                + {{(mmpp_pkg::ACCUM_BITS-7){in_dx_ff[7]}}, in_dx_ff};
   assign sum_y = {accum_y_ff[mmpp_pkg::ACCUM_BITS-1], accum_y_ff}
                + {{(mmpp_pkg::ACCUM_BITS-7){in_dy_ff[7]}}, in_dy_ff};

   always_comb begin
      if (accum_x_ff > mmpp_pkg::CLAMP_HI) begin
         mot_x = mmpp_pkg::MOTION_HI;
      end else if (accum_x_ff < mmpp_pkg::CLAMP_LO) begin
         mot_x = mmpp_pkg::MOTION_LO;
      end else begin
         mot_x = accum_x_ff[5:0];
      end
      if (accum_y_ff > mmpp_pkg::CLAMP_HI) begin
         mot_y = mmpp_pkg::MOTION_HI;
      end else if (accum_y_ff < mmpp_pkg::CLAMP_LO) begin
         mot_y = mmpp_pkg::MOTION_LO;
      end else begin
         mot_y = accum_y_ff[5:0];
      end
   end

   assign mag_x    = mot_x[5] ? (~mot_x[4:0] + 5'd1) : mot_x[4:0];
   assign mag_y    = mot_y[5] ? (~mot_y[4:0] + 5'd1) : mot_y[4:0];
   assign btn_bits = {buttons_ff[1:0], 6'd0};
   assign drain_x  = accum_x_ff - {{(mmpp_pkg::ACCUM_BITS-6){mot_x[5]}}, mot_x};
   assign drain_y  = accum_y_ff - {{(mmpp_pkg::ACCUM_BITS-6){mot_y[5]}}, mot_y};
   assign pkt_next = (pkt_count_ff < mmpp_pkg::PKT_DONE) ? pkt_count_ff + 3'd1
                                                         : pkt_count_ff;
   assign big_motion = (mot_x > mmpp_pkg::MOTION_P1) || (mot_x < mmpp_pkg::MOTION_N1)
                    || (mot_y > mmpp_pkg::MOTION_P1) || (mot_y < mmpp_pkg::MOTION_N1)
                    || (pkt_count_ff == mmpp_pkg::PKT_BYTE1)
                    || (pkt_count_ff == mmpp_pkg::PKT_BYTE2);

   always_comb begin
      shift_byte_in  = shift_byte_ff;
      bit_pointer_in = bit_pointer_ff;
      strobe_in      = strobe_ff;
      accum_x_in     = accum_x_ff;
      accum_y_in     = accum_y_ff;
      buttons_in     = buttons_ff;
      pkt_count_in   = pkt_count_ff;
      rsp_bit_in     = rsp_bit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      if (proc_word) begin
         case (mmpp_pkg::req_kind_type'(in_kind_ff))
            mmpp_pkg::REQ_FRAME: begin
               if (sum_x[mmpp_pkg::ACCUM_BITS] != sum_x[mmpp_pkg::ACCUM_BITS-1]) begin
                  accum_x_in = sum_x[mmpp_pkg::ACCUM_BITS] ? mmpp_pkg::ACCUM_MIN
                                                           : mmpp_pkg::ACCUM_MAX;
               end else begin
                  accum_x_in = sum_x[mmpp_pkg::ACCUM_BITS-1:0];
               end
               if (sum_y[mmpp_pkg::ACCUM_BITS] != sum_y[mmpp_pkg::ACCUM_BITS-1]) begin
                  accum_y_in = sum_y[mmpp_pkg::ACCUM_BITS] ? mmpp_pkg::ACCUM_MIN
                                                           : mmpp_pkg::ACCUM_MAX;
               end else begin
                  accum_y_in = sum_y[mmpp_pkg::ACCUM_BITS-1:0];
               end
               buttons_in   = in_btn_ff;
               pkt_count_in = mmpp_pkg::PKT_NONE;
            end
            mmpp_pkg::REQ_READ: begin
               rsp_valid_in = 1'b1;
               if (bit_pointer_ff < mmpp_pkg::BIT_COUNT) begin
                  rsp_bit_in     = shift_byte_ff[~bit_pointer_ff[2:0]];
                  bit_pointer_in = bit_pointer_ff + 4'd1;
               end else begin
                  rsp_bit_in = 1'b0;
               end
            end
            mmpp_pkg::REQ_WRITE: begin
               if (strobe_ff && !in_wval_ff[0]) begin
                  bit_pointer_in = 4'd0;
                  if (big_motion) begin
                     pkt_count_in = pkt_next;
                     case (pkt_next)
                        mmpp_pkg::PKT_BYTE1: begin
                           shift_byte_in = btn_bits | {2'b00, mot_x[5], mag_x[4],
                                                        mot_y[5], mag_y[4], 2'b01};
                        end
                        mmpp_pkg::PKT_BYTE2: begin
                           shift_byte_in = {2'b00, mag_x[3:0], 2'b10};
                        end
                        mmpp_pkg::PKT_BYTE3: begin
                           shift_byte_in = {2'b00, mag_y[3:0], 2'b11};
                           accum_x_in    = drain_x;
                           accum_y_in    = drain_y;
                        end
                        default: begin
                           shift_byte_in = shift_byte_ff;
                        end
                     endcase
                  end else begin
                     shift_byte_in = btn_bits
                        | (mot_y[5] ? mmpp_pkg::DIR_Y_NEG : 8'd0)
                        | ((!mot_y[5] && mot_y != 6'sd0) ? mmpp_pkg::DIR_Y_POS : 8'd0)
                        | (mot_x[5] ? mmpp_pkg::DIR_X_NEG : 8'd0)
                        | ((!mot_x[5] && mot_x != 6'sd0) ? mmpp_pkg::DIR_X_POS : 8'd0);
                     accum_x_in = drain_x;
                     accum_y_in = drain_y;
                  end
               end
               strobe_in = (in_wval_ff == mmpp_pkg::STROBE_VALUE);
            end
            default: begin
               strobe_in = strobe_ff;
            end
         endcase
      end
   end

   assign in_valid_in = req_accept || (in_valid_ff && !proc_word);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         shift_byte_ff  <= 8'd0;
         bit_pointer_ff <= 4'd0;
         strobe_ff      <= 1'b0;
         accum_x_ff     <= '0;
         accum_y_ff     <= '0;
         buttons_ff     <= 3'd0;
         pkt_count_ff   <= mmpp_pkg::PKT_NONE;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         shift_byte_ff  <= shift_byte_in;
         bit_pointer_ff <= bit_pointer_in;
         strobe_ff      <= strobe_in;
         accum_x_ff     <= accum_x_in;
         accum_y_ff     <= accum_y_in;
         buttons_ff     <= buttons_in;
         pkt_count_ff   <= pkt_count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bit_ff <= rsp_bit_in;
      if (req_accept) begin
         in_kind_ff <= req_tuser;
         in_dx_ff   <= req_tdata[7:0];
         in_dy_ff   <= req_tdata[15:8];
         in_btn_ff  <= req_tdata[18:16];
         in_wval_ff <= req_tdata[21:19];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mmpp_port_check.sv =====
// ----------------------------------------------------------------------------
// mmpp_port_check
// Port-level checks of the mouse motion packet port, bound to mouse_motion_packet_port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mouse_motion_packet_port_assert.svh"

module mmpp_port_check (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   `MMPP_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `MMPP_ASSERT_RST(a_rsp_pad, clock, reset, rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
   `MMPP_ASSERT_RST(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)
   `MMPP_ASSERT_ALL(a_reset_clears, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind mouse_motion_packet_port mmpp_port_check u_port_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
